// ===== rtl/core/ifl_pkg.sv =====
// ifl_pkg: types, codes and sizes shared by the index free-list allocator.
// Used by ifl_ctrl, ifl_dpath and index_free_list_allocator. No dependencies.
package ifl_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;

   localparam logic [2:0] MODE_ALLOC     = 3'd0;
   localparam logic [2:0] MODE_REMOVE    = 3'd1;
   localparam logic [2:0] MODE_ALLOC_RUN = 3'd2;
   localparam logic [2:0] MODE_REM_RUN   = 3'd3;
   localparam logic [2:0] MODE_CONTAINS  = 3'd4;
   localparam logic [2:0] MODE_CLEAR     = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;
   localparam logic [1:0] ST_DUP  = 2'd3;

   typedef struct packed {
      logic [2:0]       mode;
      logic [IDX_W-1:0] index_in;
      logic [CNT_W-1:0] run_length;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] index_out;
      logic [CNT_W-1:0] count_out;
      logic             present;
      logic [1:0]       status;
      logic [CNT_W-1:0] used_count;
      logic [CNT_W-1:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic init;
      logic pop;
      logic scan;
      logic copy;
      logic clr;
      logic mark;
      logic sweep;
      logic post;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic route_pop;
      logic route_scan;
      logic route_clear;
      logic mode_run;
      logic mode_rrun;
      logic hit;
      logic scan_done;
      logic copy_done;
      logic clr_done;
      logic mark_done;
      logic sweep_done;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/core/ifl_ram.sv =====
// ifl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ifl_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ifl_ctrl.sv =====
// ifl_ctrl: sequencing state machine of the allocator.
// Depends on ifl_pkg (cmd_type, sts_type).
module ifl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output ifl_pkg::cmd_type cmd,
   input  ifl_pkg::sts_type sts
);
   import ifl_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_START = 10'b0000000010,
      S_POP   = 10'b0000000100,
      S_SCAN  = 10'b0000001000,
      S_COPY  = 10'b0000010000,
      S_CLEAR = 10'b0000100000,
      S_MARK  = 10'b0001000000,
      S_SWEEP = 10'b0010000000,
      S_POST  = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.init = 1'b1;
            if (sts.route_pop) state_in = S_POP;
            else if (sts.route_scan) state_in = S_SCAN;
            else if (sts.route_clear) state_in = S_CLEAR;
            else state_in = S_FIN;
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_FIN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               if (sts.mode_run && sts.hit) state_in = S_COPY;
               else if (sts.mode_rrun && !sts.hit) state_in = S_MARK;
               else state_in = S_POST;
            end
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            if (sts.copy_done) state_in = S_POST;
         end
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) state_in = S_SCAN;
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            if (sts.mark_done) state_in = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) state_in = S_POST;
         end
         S_POST: begin
            cmd.post = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== rtl/core/ifl_dpath.sv =====
// ifl_dpath: counters, free-list RAM, scratch bitmap RAM and result register.
// Depends on ifl_pkg and ifl_ram.
module ifl_dpath (
   input  logic             clock,
   input  logic             reset,
   input  ifl_pkg::cmd_type cmd,
   output ifl_pkg::sts_type sts,
   input  ifl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ifl_pkg::rsp_type rsp_data
);
   import ifl_pkg::*;

   logic [2:0]       mode_ff, mode_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] hw_ff, hw_in, ft_ff, ft_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in, kptr_ff, kptr_in, vaddr_ff, vaddr_in;
   logic [CNT_W-1:0] run_ff, run_in, wptr_ff, wptr_in, cnt_ff, cnt_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [IDX_W-1:0] start_ff, start_in, last_ff, last_in;
   logic             vld_ff, vld_in, hit_ff, hit_in;
   logic [IDX_W-1:0] r_index_ff, r_index_in;
   logic [CNT_W-1:0] r_count_ff, r_count_in;
   logic             r_present_ff, r_present_in;
   logic [1:0]       r_status_ff, r_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             fl_we, mp_we;
   logic [IDX_W-1:0] fl_wa, fl_wd, fl_ra, fl_rd, mp_wa, mp_ra;
   logic [0:0]       mp_wd, mp_rd;

   logic [CNT_W:0]   end12, hw12;
   logic             in_range;

   assign end12    = {2'b00, idx_ff} + {1'b0, len_ff};
   assign hw12     = {1'b0, hw_ff};
   assign in_range = (idx_ff != '0) && ({1'b0, idx_ff} < hw_ff);

   always_comb begin
      sts             = '0;
      sts.route_pop   = (mode_ff == MODE_ALLOC) && (ft_ff != '0);
      sts.route_scan  = ((mode_ff == MODE_REMOVE) && in_range)
                     || ((mode_ff == MODE_ALLOC_RUN) && (len_ff != '0))
                     || ((mode_ff == MODE_CONTAINS) && in_range);
      sts.route_clear = (mode_ff == MODE_REM_RUN) && (idx_ff != '0) && (end12 <= hw12);
      sts.mode_run    = (mode_ff == MODE_ALLOC_RUN);
      sts.mode_rrun   = (mode_ff == MODE_REM_RUN);
      sts.hit         = hit_ff;
      sts.scan_done   = hit_ff || ((ptr_ff == ft_ff) && !vld_ff);
      sts.copy_done   = (ptr_ff == ft_ff) && !vld_ff;
      sts.clr_done    = (kptr_ff == hw_ff);
      sts.mark_done   = ({1'b0, kptr_ff} == end12);
      sts.sweep_done  = (kptr_ff == hw_ff) && !vld_ff;
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      logic             hit_now, cont;
      logic [CNT_W-1:0] run_new;
      logic [IDX_W-1:0] start_new;
      logic [CNT_W:0]   v12;

      mode_in = mode_ff;   idx_in = idx_ff;     len_in = len_ff;
      hw_in = hw_ff;       ft_in = ft_ff;       ptr_in = ptr_ff;
      kptr_in = kptr_ff;   vaddr_in = vaddr_ff; run_in = run_ff;
      wptr_in = wptr_ff;   cnt_in = cnt_ff;     keep_in = keep_ff;
      start_in = start_ff; last_in = last_ff;   vld_in = vld_ff;
      hit_in = hit_ff;
      r_index_in = r_index_ff;     r_count_in = r_count_ff;
      r_present_in = r_present_ff; r_status_in = r_status_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      fl_we = 1'b0; fl_wa = wptr_ff[IDX_W-1:0]; fl_wd = fl_rd;
      fl_ra = ptr_ff[IDX_W-1:0];
      mp_we = 1'b0; mp_wa = kptr_ff[IDX_W-1:0]; mp_wd = 1'b0;
      mp_ra = kptr_ff[IDX_W-1:0];
      hit_now = 1'b0;
      v12     = {2'b00, fl_rd};
      cont    = (start_ff != '0)
             && (v12 == ({2'b00, start_ff} + {1'b0, run_ff}));
      run_new   = cont ? run_ff + 1'b1 : CNT_W'(1);
      start_new = cont ? start_ff : fl_rd;

      if (cmd.load) begin
         mode_in = req_data.mode;
         idx_in  = req_data.index_in;
         len_in  = req_data.run_length;
      end

      if (cmd.init) begin
         r_index_in = '0; r_count_in = '0; r_present_in = 1'b0; r_status_in = ST_OK;
         ptr_in = '0; kptr_in = '0; vld_in = 1'b0; hit_in = 1'b0;
         start_in = '0; run_in = '0;
         case (mode_ff)
            MODE_ALLOC: begin
               if (ft_ff != '0) begin
                  fl_ra = IDX_W'(ft_ff - 1'b1);
               end else if (hw_ff >= CNT_W'(CAPACITY)) begin
                  r_status_in = ST_FULL;
               end else begin
                  r_index_in = hw_ff[IDX_W-1:0];
                  r_count_in = CNT_W'(1);
                  hw_in      = hw_ff + 1'b1;
               end
            end
            MODE_REMOVE:  if (!in_range) r_status_in = ST_BAD;
            MODE_REM_RUN: if (!sts.route_clear) r_status_in = ST_BAD;
            MODE_CLEAR: begin
               hw_in = CNT_W'(1);
               ft_in = '0;
            end
            default: ;
         endcase
      end

      if (cmd.pop) begin
         r_index_in = fl_rd;
         r_count_in = CNT_W'(1);
         ft_in      = ft_ff - 1'b1;
      end

      if (cmd.scan) begin
         if (vld_ff && !hit_ff) begin
            case (mode_ff)
               MODE_ALLOC_RUN: begin
                  start_in = start_new;
                  run_in   = run_new;
                  if (run_new == len_ff) begin
                     hit_now    = 1'b1;
                     r_index_in = start_new;
                     r_count_in = run_new;
                     wptr_in    = vaddr_ff + 1'b1 - run_new;
                  end
               end
               MODE_REM_RUN: begin
                  if ((v12 >= {2'b00, idx_ff}) && (v12 < end12)) begin
                     hit_now = 1'b1;
                  end else begin
                     mp_we = 1'b1;
                     mp_wa = fl_rd;
                     mp_wd = 1'b1;
                  end
               end
               default: hit_now = (fl_rd == idx_ff);
            endcase
         end
         if (hit_now) begin
            hit_in = 1'b1;
            vld_in = 1'b0;
            ptr_in = vaddr_ff + 1'b1;  // copy source for a found run
         end else if (!hit_ff && (ptr_ff < ft_ff)) begin
            fl_ra    = ptr_ff[IDX_W-1:0];
            ptr_in   = ptr_ff + 1'b1;
            vaddr_in = ptr_ff;
            vld_in   = 1'b1;
         end else begin
            vld_in = 1'b0;
         end
         if (sts.scan_done && !hit_ff) kptr_in = {1'b0, idx_ff};
      end

      if (cmd.copy) begin
         if (vld_ff) begin
            fl_we   = 1'b1;
            fl_wa   = wptr_ff[IDX_W-1:0];
            fl_wd   = fl_rd;
            wptr_in = wptr_ff + 1'b1;
         end
         if (ptr_ff < ft_ff) begin
            fl_ra  = ptr_ff[IDX_W-1:0];
            ptr_in = ptr_ff + 1'b1;
            vld_in = 1'b1;
         end else begin
            vld_in = 1'b0;
         end
      end

      if (cmd.clr && (kptr_ff < hw_ff)) begin
         mp_we   = 1'b1;
         mp_wd   = 1'b0;
         kptr_in = kptr_ff + 1'b1;
      end

      if (cmd.mark) begin
         if (sts.mark_done) begin
            kptr_in = CNT_W'(1);
            cnt_in  = '0;
            keep_in = '0;
            last_in = '0;
            vld_in  = 1'b0;
         end else begin
            mp_we   = 1'b1;
            mp_wd   = 1'b1;
            kptr_in = kptr_ff + 1'b1;
         end
      end

      if (cmd.sweep) begin
         if (vld_ff) begin
            if (mp_rd[0]) begin
               fl_we  = 1'b1;
               fl_wa  = cnt_ff[IDX_W-1:0];
               fl_wd  = vaddr_ff[IDX_W-1:0];
               cnt_in = cnt_ff + 1'b1;
            end else begin
               // highest index still in use so far sets the trimmed count
               last_in = vaddr_ff[IDX_W-1:0];
               keep_in = cnt_ff;
            end
         end
         if (kptr_ff < hw_ff) begin
            mp_ra    = kptr_ff[IDX_W-1:0];
            kptr_in  = kptr_ff + 1'b1;
            vaddr_in = kptr_ff;
            vld_in   = 1'b1;
         end else begin
            vld_in = 1'b0;
         end
      end

      if (cmd.post) begin
         case (mode_ff)
            MODE_REMOVE: begin
               if (hit_ff) r_status_in = ST_DUP;
               else if (ft_ff >= CNT_W'(CAPACITY)) r_status_in = ST_FULL;
               else begin
                  fl_we = 1'b1;
                  fl_wa = ft_ff[IDX_W-1:0];
                  fl_wd = idx_ff;
                  ft_in = ft_ff + 1'b1;
               end
            end
            MODE_ALLOC_RUN: begin
               if (hit_ff) ft_in = ft_ff - r_count_ff;
               else if ((hw12 + {1'b0, len_ff}) > (CNT_W+1)'(CAPACITY)) begin
                  r_status_in = ST_FULL;
               end else begin
                  r_index_in = hw_ff[IDX_W-1:0];
                  r_count_in = len_ff;
                  hw_in      = hw_ff + len_ff;
               end
            end
            MODE_REM_RUN: begin
               if (hit_ff) r_status_in = ST_DUP;
               else begin
                  ft_in = keep_ff;
                  hw_in = {1'b0, last_ff} + 1'b1;
               end
            end
            MODE_CONTAINS: r_present_in = !hit_ff;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.index_out  = r_index_ff;
         rsp_data_in.count_out  = r_count_ff;
         rsp_data_in.present    = r_present_ff;
         rsp_data_in.status     = r_status_ff;
         rsp_data_in.used_count = hw_ff;
         rsp_data_in.free_count = ft_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= CNT_W'(1);
         ft_ff        <= '0;
         vld_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hw_ff        <= hw_in;
         ft_ff        <= ft_in;
         vld_ff       <= vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;   idx_ff <= idx_in;     len_ff <= len_in;
      ptr_ff <= ptr_in;     kptr_ff <= kptr_in;   vaddr_ff <= vaddr_in;
      run_ff <= run_in;     wptr_ff <= wptr_in;   cnt_ff <= cnt_in;
      keep_ff <= keep_in;   start_ff <= start_in; last_ff <= last_in;
      r_index_ff <= r_index_in;     r_count_ff <= r_count_in;
      r_present_ff <= r_present_in; r_status_ff <= r_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   ifl_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_list (
      .clock   (clock),
      .wr_en   (fl_we),
      .wr_addr (fl_wa),
      .wr_data (fl_wd),
      .rd_addr (fl_ra),
      .rd_data (fl_rd)
   );

   ifl_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_free_map (
      .clock   (clock),
      .wr_en   (mp_we),
      .wr_addr (mp_wa),
      .wr_data (mp_wd),
      .rd_addr (mp_ra),
      .rd_data (mp_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/index_free_list_allocator.sv =====
// Index free-list allocator for a 1024-slot table; index 0 is reserved.
// req channel: one item (mode, index_in, run_length) per operation, accepted
// when req_valid is high and req_stall low. rsp channel: exactly one result
// item per request, in order, held in an output register while rsp_stall.
// One item is worked at a time; req_stall is high from acceptance until the
// result is loaded into the output register, so the next item may enter
// while a result still waits on the rsp side.
// Steps per item: alloc, clear and rejected requests go straight to the
//   result; alloc with free entries pops the free list; remove and contains
//   scan the free list; alloc_run scans it and, on a found run, copies the
//   rest of the list down; remove_run clears the scratch bitmap, scans, marks
//   the run and rebuilds the free list in order, with one RAM access on each
//   port per cycle.
// Reset: synchronous, clears the count to 1 and empties the free list;
// RAM contents need no clearing. A stalled result holds the block in its
// finish state until the receiver takes the previous result.
// Depends on ifl_pkg, ifl_ctrl, ifl_dpath, ifl_ram.
module index_free_list_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ifl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ifl_pkg::rsp_type rsp_data
);
   import ifl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ifl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ifl_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // one item at a time: an accepted item closes the input
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while an item is in work");

   // free entries are distinct indexes in 1..count-1, so the free count stays below the count
   a_free_below_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.free_count < rsp_data.used_count))
      else $error("free count not below used count");

   // a result is only loaded when the output slot is free
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over a waiting result");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for index_free_list_allocator.
// Directed and random requests with random idling on both channels, checked
// against an in-bench model of the free list. Depends on ifl_pkg and the RTL.
import ifl_pkg::*;

class alloc_scoreboard;
   logic [IDX_W-1:0] slots [CAPACITY];
   int               free_total;
   int               used_count;
   rsp_type          expected_q [$];
   int               errors;

   function new();
      free_total = 0;
      used_count = 1;
      errors     = 0;
   endfunction

   function bit [CAPACITY-1:0] free_map();
      bit [CAPACITY-1:0] map;
      map = '0;
      for (int i = 0; i < free_total; i++) map[slots[i]] = 1'b1;
      return map;
   endfunction

   // Works out the result of one accepted request and updates the state.
   function void note_request(req_type r);
      rsp_type           e;
      bit [CAPACITY-1:0] map;
      int                idx, len, run_start, run_len, v;
      bit                found;
      e   = '0;
      idx = r.index_in;
      len = r.run_length;
      case (r.mode)
         MODE_ALLOC: begin
            if (free_total > 0) begin
               free_total--;
               e.index_out = slots[free_total];
               e.count_out = CNT_W'(1);
            end else if (used_count >= CAPACITY) begin
               e.status = ST_FULL;
            end else begin
               e.index_out = IDX_W'(used_count);
               e.count_out = CNT_W'(1);
               used_count++;
            end
         end
         MODE_REMOVE: begin
            if (idx == 0 || idx >= used_count) begin
               e.status = ST_BAD;
            end else begin
               map = free_map();
               if (map[idx]) e.status = ST_DUP;
               else if (free_total >= CAPACITY) e.status = ST_FULL;
               else slots[free_total++] = IDX_W'(idx);
            end
         end
         MODE_ALLOC_RUN: begin
            if (len != 0) begin
               run_start = 0;
               run_len   = 0;
               found     = 0;
               for (int i = 0; i < free_total && !found; i++) begin
                  v = slots[i];
                  if (run_start != 0 && v == run_start + run_len) begin
                     run_len++;
                  end else begin
                     run_start = v;
                     run_len   = 1;
                  end
                  if (run_len == len) begin
                     for (int k = i + 1; k < free_total; k++) slots[k - run_len] = slots[k];
                     free_total -= run_len;
                     e.index_out = IDX_W'(run_start);
                     e.count_out = CNT_W'(run_len);
                     found = 1;
                  end
               end
               if (!found) begin
                  if (used_count + len > CAPACITY) begin
                     e.status = ST_FULL;
                  end else begin
                     e.index_out = IDX_W'(used_count);
                     e.count_out = CNT_W'(len);
                     used_count += len;
                  end
               end
            end
         end
         MODE_REM_RUN: begin
            if (idx == 0 || idx + len > used_count) begin
               e.status = ST_BAD;
            end else begin
               map = free_map();
               for (int k = 0; k < len; k++) if (map[idx + k]) e.status = ST_DUP;
               if (e.status == ST_OK) begin
                  for (int k = 0; k < len; k++) map[idx + k] = 1'b1;
                  free_total = 0;
                  for (int k = 1; k < used_count; k++) if (map[k]) slots[free_total++] = IDX_W'(k);
                  // free indexes at the top go back by lowering the count
                  while (free_total > 0 && slots[free_total - 1] == used_count - 1) begin
                     free_total--;
                     used_count--;
                  end
               end
            end
         end
         MODE_CONTAINS: begin
            if (idx != 0 && idx < used_count) begin
               map = free_map();
               e.present = !map[idx];
            end
         end
         MODE_CLEAR: begin
            used_count = 1;
            free_total = 0;
         end
         default: ;
      endcase
      e.used_count = CNT_W'(used_count);
      e.free_count = CNT_W'(free_total);
      expected_q.push_back(e);
   endfunction

   function void field_check(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_result(rsp_type a);
      rsp_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result item %h", $time, a);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      field_check("index_out", e.index_out, a.index_out);
      field_check("count_out", e.count_out, a.count_out);
      field_check("present", e.present, a.present);
      field_check("status", e.status, a.status);
      field_check("used_count", e.used_count, a.used_count);
      field_check("free_count", e.free_count, a.free_count);
   endfunction
endclass

module testbench;
   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 20000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   alloc_scoreboard sb = new();
   bit  calm = 0;
   int  cycles = 0;

   index_free_list_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // receiver stalls in random bursts
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (!calm && burst == 0 && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 7);
         if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send(logic [2:0] mode, int idx, int len);
      req_type r;
      r.mode       = mode;
      r.index_in   = IDX_W'(idx);
      r.run_length = CNT_W'(len);
      @(negedge clock);
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic pause(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // drop valid first so the last item is not taken twice
   task automatic drain();
      pause(1);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_random();
      int pick, hw, idx, len;
      logic [2:0] mode;
      hw   = sb.used_count;
      pick = $urandom_range(0, 99);
      idx  = (hw > 1) ? $urandom_range(1, hw - 1) : 1;
      len  = $urandom_range(1, 6);
      if (pick < 30) begin
         mode = MODE_ALLOC;
      end else if (pick < 55) begin
         mode = MODE_REMOVE;
      end else if (pick < 67) begin
         mode = MODE_ALLOC_RUN;
      end else if (pick < 77) begin
         mode = MODE_REM_RUN;
         if (hw > idx) len = $urandom_range(0, (hw - idx < 6) ? hw - idx : 6);
      end else if (pick < 92) begin
         mode = MODE_CONTAINS;
      end else if (pick < 95 || hw > 400) begin
         mode = MODE_CLEAR;
      end else begin
         // noise: any mode, any field value
         mode = 3'($urandom_range(0, 7));
         idx  = $urandom_range(0, 1023);
         len  = $urandom_range(0, 1024);
      end
      if ($urandom_range(0, 19) == 0) idx = $urandom_range(0, 1023);
      send(mode, idx, len);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send(MODE_ALLOC, 0, 0);
      send(MODE_ALLOC, 1023, 1024);
      send(MODE_ALLOC, 0, 0);
      send(MODE_REMOVE, 2, 0);
      send(MODE_REMOVE, 2, 0);         // already free
      send(MODE_REMOVE, 0, 0);         // reserved index
      send(MODE_REMOVE, 1023, 0);      // above the count
      send(MODE_CONTAINS, 2, 0);
      send(MODE_CONTAINS, 1, 0);
      send(MODE_CONTAINS, 0, 0);
      send(MODE_CONTAINS, 1023, 0);
      send(MODE_ALLOC, 0, 0);
      send(MODE_ALLOC_RUN, 5, 0);      // empty run
      send(MODE_ALLOC_RUN, 0, 1024);   // full
      send(3'd6, 1023, 1024);
      send(3'd7, 0, 0);
      send(MODE_REM_RUN, 0, 1);
      send(MODE_REM_RUN, 1, 0);
      send(MODE_REM_RUN, 2, 2);
      send(MODE_REM_RUN, 1, 1);
      send(MODE_ALLOC_RUN, 0, 1023);
      send(MODE_ALLOC, 0, 0);          // table full
      send(MODE_REM_RUN, 1, 1023);
      send(MODE_CLEAR, 0, 0);
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - 150) calm = 1;
         if (n == RANDOM_ITEMS / 2) drain();
         send_random();
         if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 7));
      end
      pause(1);
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
